### sv/text_console_glyph_renderer_core_macros.svh
// assertion macros for the text console glyph renderer
// sampled on clk, disabled while rst_n is low; no other dependencies
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_CORE_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge
`define TCGR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TCGR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TCGR_ASSERT_ALWAYS(label, cond, msg)
`define TCGR_ASSERT_IMPL(label, ante, cons, msg)
`define TCGR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### sv/tcgr_pkg.sv
// shared types and constants of the text console glyph renderer
// used by every module of the block but tcgr_ram; depends on nothing
package tcgr_pkg;

  // geometry limits and cell shape
  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 128;
  localparam int TAB_WIDTH   = 4;
  localparam int COL_W       = 8;
  localparam int ROW_W       = 7;
  localparam int LINE_W      = 5;
  localparam logic [LINE_W-1:0] LINE_LAST = 5'd31;

  // font store split into left and right byte halves
  localparam int FONT_ADDR_W    = 14;
  localparam int FONT_HALF_DEPTH = 8192;
  localparam int FONT_HALF_AW   = 13;
  localparam int BYTE_W         = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // input operations
  localparam logic [1:0] OP_PUT_CHAR = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_FONT_WR  = 2'd2;

  // control characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // result commands
  localparam logic [1:0] CMD_GLYPH_ROW   = 2'd0;
  localparam logic [1:0] CMD_FILL_CELL   = 2'd1;
  localparam logic [1:0] CMD_SCROLL      = 2'd2;
  localparam logic [1:0] CMD_FILL_SCREEN = 2'd3;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ROWS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL       = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [13:0] font_address;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] row_mask;
    logic [31:0] color;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        enable;
    logic [8:0]  columns;
    logic [7:0]  text_rows;
    logic [31:0] foreground_color;
    logic [31:0] fill_color;
  } cfg_t;

  // classified work for the back end
  typedef enum logic [2:0] {
    KIND_FONT_WR,
    KIND_CLEAR,
    KIND_GLYPH,
    KIND_NEWLINE,
    KIND_RETURN,
    KIND_TAB,
    KIND_BACKSPACE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_code;
    logic [13:0] font_address;
    logic [7:0]  font_byte;
  } entry_t;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_WRAP,
    ST_FILL,
    ST_GLYPH,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

endpackage

### sv/tcgr_ram.sv
// generic simple dual-port ram with one write port and a registered read
// depends on nothing
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/tcgr_fifo.sv
// short register queue carrying classified transactions from front to back
// depends on tcgr_pkg
module tcgr_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tcgr_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output tcgr_pkg::entry_t pop_entry,
  output logic             not_empty
);

  localparam int PTR_W = (tcgr_pkg::QUEUE_DEPTH > 1) ? $clog2(tcgr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcgr_pkg::QUEUE_DEPTH + 1);

  tcgr_pkg::entry_t entries_r [tcgr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pointer advance with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tcgr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tcgr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  assign full      = (count_r == CNT_W'(tcgr_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = entries_r[rd_ptr_r];

endmodule

### sv/tcgr_front.sv
// front end: accepts input transactions and sorts them into work kinds
// depends on tcgr_pkg; feeds tcgr_fifo
module tcgr_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  tcgr_pkg::in_item_t in_data,
  input  logic               enable,
  input  logic               q_full,
  output logic               q_push,
  output tcgr_pkg::entry_t   q_entry
);

  logic            keep;
  tcgr_pkg::kind_t kind;

  // classify by operation and character code; dropped items still handshake
  always_comb begin
    keep = 1'b0;
    kind = tcgr_pkg::KIND_GLYPH;
    unique case (in_data.op)
      tcgr_pkg::OP_FONT_WR: begin
        keep = 1'b1;
        kind = tcgr_pkg::KIND_FONT_WR;
      end
      tcgr_pkg::OP_CLEAR: begin
        keep = enable;
        kind = tcgr_pkg::KIND_CLEAR;
      end
      tcgr_pkg::OP_PUT_CHAR: begin
        keep = enable;
        unique case (in_data.char_code)
          tcgr_pkg::CH_NUL: keep = 1'b0;
          tcgr_pkg::CH_LF:  kind = tcgr_pkg::KIND_NEWLINE;
          tcgr_pkg::CH_CR:  kind = tcgr_pkg::KIND_RETURN;
          tcgr_pkg::CH_TAB: kind = tcgr_pkg::KIND_TAB;
          tcgr_pkg::CH_BS:  kind = tcgr_pkg::KIND_BACKSPACE;
          default:          kind = tcgr_pkg::KIND_GLYPH;
        endcase
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready             = !q_full;
  assign q_push               = in_valid && !q_full && keep;
  assign q_entry.kind         = kind;
  assign q_entry.char_code    = in_data.char_code;
  assign q_entry.font_address = in_data.font_address;
  assign q_entry.font_byte    = in_data.font_byte;

endmodule

### sv/tcgr_back.sv
// back end: cursor sequencer, font store and result register
// depends on tcgr_pkg, tcgr_ram and the assertion macro header
`include "text_console_glyph_renderer_core_macros.svh"

module tcgr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcgr_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  tcgr_pkg::entry_t    q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tcgr_pkg::out_item_t out_data
);

  tcgr_pkg::state_t state_r, state_nxt;
  tcgr_pkg::kind_t  kind_r;
  logic [7:0]       ch_r;

  logic [tcgr_pkg::COL_W-1:0]  col_r, draw_col_r, draw_col_nxt;
  logic [tcgr_pkg::ROW_W-1:0]  row_r, draw_row_r, draw_row_nxt;
  logic [tcgr_pkg::COL_W:0]    step_col_r, step_col_nxt;
  logic [tcgr_pkg::ROW_W:0]    step_row_r, step_row_nxt;
  logic                        scroll_r;
  logic [tcgr_pkg::LINE_W-1:0] line_r, rd_line;

  logic                out_valid_r;
  tcgr_pkg::out_item_t out_data_r, out_nxt;
  logic                out_free, emit;

  logic [8:0]               cols_eff;
  logic [7:0]               rows_eff;
  logic                     bs_origin;
  logic                     wrap_col, wrap_scroll;
  logic [tcgr_pkg::ROW_W:0] row_w;

  logic                              font_wr, we_hi, we_lo;
  logic [tcgr_pkg::FONT_HALF_AW-1:0] rd_addr;
  logic [tcgr_pkg::BYTE_W-1:0]       hi_data, lo_data;

  // geometry saturated into the supported range
  always_comb begin
    if (cfg.columns == '0) begin
      cols_eff = 9'd1;
    end else if (cfg.columns > 9'(tcgr_pkg::MAX_COLS)) begin
      cols_eff = 9'(tcgr_pkg::MAX_COLS);
    end else begin
      cols_eff = cfg.columns;
    end
    if (cfg.text_rows == '0) begin
      rows_eff = 8'd1;
    end else if (cfg.text_rows > 8'(tcgr_pkg::MAX_ROWS)) begin
      rows_eff = 8'(tcgr_pkg::MAX_ROWS);
    end else begin
      rows_eff = cfg.text_rows;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign bs_origin = (col_r == '0) && (row_r == '0);

  // cursor movement for the current character
  always_comb begin
    step_col_nxt = {1'b0, col_r};
    step_row_nxt = {1'b0, row_r};
    draw_col_nxt = col_r;
    draw_row_nxt = row_r;
    case (kind_r)
      tcgr_pkg::KIND_NEWLINE: begin
        step_col_nxt = '0;
        step_row_nxt = {1'b0, row_r} + 1'b1;
      end
      tcgr_pkg::KIND_RETURN: step_col_nxt = '0;
      tcgr_pkg::KIND_TAB: begin
        step_col_nxt = {1'b0, col_r} + (tcgr_pkg::COL_W + 1)'(tcgr_pkg::TAB_WIDTH);
      end
      tcgr_pkg::KIND_BACKSPACE: begin
        if (col_r != '0) begin
          step_col_nxt = {1'b0, col_r} - 1'b1;
          draw_col_nxt = col_r - 1'b1;
        end else begin
          step_col_nxt = cols_eff - 1'b1;
          step_row_nxt = {1'b0, row_r} - 1'b1;
          draw_col_nxt = step_col_nxt[tcgr_pkg::COL_W-1:0];
          draw_row_nxt = step_row_nxt[tcgr_pkg::ROW_W-1:0];
        end
      end
      tcgr_pkg::KIND_GLYPH: step_col_nxt = {1'b0, col_r} + 1'b1;
      default: ;
    endcase
  end

  // column wrap, then scroll past the last row
  always_comb begin
    wrap_col    = (step_col_r >= cols_eff);
    row_w       = wrap_col ? step_row_r + 1'b1 : step_row_r;
    wrap_scroll = (row_w >= rows_eff);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcgr_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_entry.kind == tcgr_pkg::KIND_FONT_WR) begin
            state_nxt = tcgr_pkg::ST_IDLE;
          end else if (q_entry.kind == tcgr_pkg::KIND_CLEAR) begin
            state_nxt = tcgr_pkg::ST_CLEAR;
          end else begin
            state_nxt = tcgr_pkg::ST_STEP;
          end
        end
      end
      tcgr_pkg::ST_STEP: begin
        if (kind_r == tcgr_pkg::KIND_BACKSPACE && bs_origin) begin
          state_nxt = tcgr_pkg::ST_IDLE;
        end else begin
          state_nxt = tcgr_pkg::ST_WRAP;
        end
      end
      tcgr_pkg::ST_WRAP: begin
        if (kind_r == tcgr_pkg::KIND_BACKSPACE) begin
          state_nxt = tcgr_pkg::ST_FILL;
        end else if (kind_r == tcgr_pkg::KIND_GLYPH) begin
          state_nxt = tcgr_pkg::ST_GLYPH;
        end else if (wrap_scroll) begin
          state_nxt = tcgr_pkg::ST_SCROLL;
        end else begin
          state_nxt = tcgr_pkg::ST_IDLE;
        end
      end
      tcgr_pkg::ST_FILL: begin
        if (out_free) begin
          state_nxt = scroll_r ? tcgr_pkg::ST_SCROLL : tcgr_pkg::ST_IDLE;
        end
      end
      tcgr_pkg::ST_GLYPH: begin
        if (out_free && line_r == tcgr_pkg::LINE_LAST) begin
          state_nxt = scroll_r ? tcgr_pkg::ST_SCROLL : tcgr_pkg::ST_IDLE;
        end
      end
      tcgr_pkg::ST_SCROLL, tcgr_pkg::ST_CLEAR: begin
        if (out_free) begin
          state_nxt = tcgr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcgr_pkg::ST_IDLE;
    endcase
  end

  // outputs: queue pop, font access and the result to load
  always_comb begin
    q_pop   = 1'b0;
    emit    = 1'b0;
    rd_line = line_r;
    out_nxt = '{command: tcgr_pkg::CMD_SCROLL, pixel_x: '0, pixel_y: '0,
                row_mask: '0, color: cfg.fill_color, last: 1'b1};
    unique case (state_r)
      tcgr_pkg::ST_IDLE: q_pop = q_valid;
      tcgr_pkg::ST_CLEAR: begin
        emit            = out_free;
        out_nxt.command = tcgr_pkg::CMD_FILL_SCREEN;
      end
      tcgr_pkg::ST_FILL: begin
        emit            = out_free;
        out_nxt.command = tcgr_pkg::CMD_FILL_CELL;
        out_nxt.pixel_x = {draw_col_r, 4'b0000};
        out_nxt.pixel_y = {draw_row_r, 5'b00000};
        out_nxt.last    = !scroll_r;
      end
      tcgr_pkg::ST_GLYPH: begin
        emit             = out_free;
        rd_line          = out_free ? line_r + 1'b1 : line_r;
        out_nxt.command  = tcgr_pkg::CMD_GLYPH_ROW;
        out_nxt.pixel_x  = {draw_col_r, 4'b0000};
        out_nxt.pixel_y  = {draw_row_r, line_r};
        out_nxt.row_mask = {hi_data, lo_data};
        out_nxt.color    = cfg.foreground_color;
        out_nxt.last     = (line_r == tcgr_pkg::LINE_LAST) && !scroll_r;
      end
      tcgr_pkg::ST_SCROLL: emit = out_free;
      default: ;
    endcase
  end

  // font store: even bytes are the left half of a glyph line
  assign font_wr = q_pop && (q_entry.kind == tcgr_pkg::KIND_FONT_WR);
  assign we_hi   = font_wr && !q_entry.font_address[0];
  assign we_lo   = font_wr && q_entry.font_address[0];
  assign rd_addr = {ch_r, rd_line};

  tcgr_ram #(
    .WIDTH (tcgr_pkg::BYTE_W),
    .DEPTH (tcgr_pkg::FONT_HALF_DEPTH)
  ) u_font_hi (
    .clk     (clk),
    .wr_en   (we_hi),
    .wr_addr (q_entry.font_address[tcgr_pkg::FONT_ADDR_W-1:1]),
    .wr_data (q_entry.font_byte),
    .rd_addr (rd_addr),
    .rd_data (hi_data)
  );

  tcgr_ram #(
    .WIDTH (tcgr_pkg::BYTE_W),
    .DEPTH (tcgr_pkg::FONT_HALF_DEPTH)
  ) u_font_lo (
    .clk     (clk),
    .wr_en   (we_lo),
    .wr_addr (q_entry.font_address[tcgr_pkg::FONT_ADDR_W-1:1]),
    .wr_data (q_entry.font_byte),
    .rd_addr (rd_addr),
    .rd_data (lo_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcgr_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      scroll_r    <= 1'b0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tcgr_pkg::ST_WRAP) begin
        col_r    <= wrap_col ? '0 : step_col_r[tcgr_pkg::COL_W-1:0];
        row_r    <= wrap_scroll ? tcgr_pkg::ROW_W'(rows_eff - 1'b1)
                                : row_w[tcgr_pkg::ROW_W-1:0];
        scroll_r <= wrap_scroll;
      end else if (state_r == tcgr_pkg::ST_CLEAR && out_free) begin
        col_r <= '0;
        row_r <= '0;
      end
      if (state_r == tcgr_pkg::ST_STEP) begin
        line_r <= '0;
      end else if (state_r == tcgr_pkg::ST_GLYPH && out_free) begin
        line_r <= line_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_entry.kind;
      ch_r   <= q_entry.char_code;
    end
    if (state_r == tcgr_pkg::ST_STEP) begin
      step_col_r <= step_col_nxt;
      step_row_r <= step_row_nxt;
      draw_col_r <= draw_col_nxt;
      draw_row_r <= draw_row_nxt;
    end
    if (emit) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer consistency checks
  `TCGR_ASSERT_IMPL(a_glyph_kind, state_r == tcgr_pkg::ST_GLYPH, kind_r == tcgr_pkg::KIND_GLYPH, "glyph rows for a non-glyph transaction")
  `TCGR_ASSERT_IMPL(a_fill_kind, state_r == tcgr_pkg::ST_FILL, kind_r == tcgr_pkg::KIND_BACKSPACE, "cell fill outside backspace")
  `TCGR_ASSERT_IMPL(a_scroll_flag, state_r == tcgr_pkg::ST_SCROLL, scroll_r, "scroll issued without a row overflow")
  `TCGR_ASSERT_NEXT(a_glyph_end, state_r == tcgr_pkg::ST_GLYPH && out_free && line_r == tcgr_pkg::LINE_LAST, state_r != tcgr_pkg::ST_GLYPH, "glyph ran past its last line")

endmodule

### sv/text_console_glyph_renderer_core.sv
// Text console glyph renderer. A put-character transaction with any byte but NUL,
// BS, TAB, LF or CR yields 32 glyph-row results, one per cycle while the output is
// not stalled, read from the 16x32 font store. It passes dequeue, cursor move, wrap
// and its glyph lines, plus a scroll if it scrolls; the single read port of the font
// store delivers one 16-bit glyph line per cycle. Newline, return and tab pass
// dequeue, cursor move, wrap and any scroll; backspace also fills a cell, but does
// nothing at the origin; clear fills the screen and a font byte write is stored at
// dequeue. A two-entry queue lets the input side keep accepting while results drain.
// The font store is not cleared after reset: a glyph must be written before it is
// drawn. Configuration must be written while idle; the block does not enforce it.
// depends on tcgr_pkg, tcgr_front, tcgr_fifo and tcgr_back
module text_console_glyph_renderer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tcgr_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tcgr_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [tcgr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tcgr_pkg::cfg_t   cfg_r;
  tcgr_pkg::entry_t push_entry, pop_entry;
  logic             q_push, q_pop, q_full, q_not_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable           <= 1'b0;
      cfg_r.columns          <= 9'd1;
      cfg_r.text_rows        <= 8'd1;
      cfg_r.foreground_color <= '0;
      cfg_r.fill_color       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcgr_pkg::REG_ENABLE:     cfg_r.enable           <= cfg_data[0];
        tcgr_pkg::REG_COLUMNS:    cfg_r.columns          <= cfg_data[8:0];
        tcgr_pkg::REG_TEXT_ROWS:  cfg_r.text_rows        <= cfg_data[7:0];
        tcgr_pkg::REG_FOREGROUND: cfg_r.foreground_color <= cfg_data;
        tcgr_pkg::REG_FILL:       cfg_r.fill_color       <= cfg_data;
        default: ;
      endcase
    end
  end

  tcgr_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .enable   (cfg_r.enable),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  tcgr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_not_empty)
  );

  tcgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
